// ===== design/cwpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cwpm_pkg;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_DIM      = 4096;
    localparam int CORDIC_STEPS = 24;
    localparam int QUO_BITS     = 19;
    localparam int CFG_W        = 13;
    localparam int COORD_W      = 12;
    localparam int COLOR_W      = 24;

    localparam logic [2:0] REG_FOCAL       = 3'd0;
    localparam logic [2:0] REG_SOURCE_ROWS = 3'd1;
    localparam logic [2:0] REG_SOURCE_COLS = 3'd2;
    localparam logic [2:0] REG_TARGET_ROWS = 3'd3;
    localparam logic [2:0] REG_TARGET_COLS = 3'd4;

    localparam logic [15:0] KF = 16'((652032874 + (1 << 13)) >> 14);

    localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
    };

    function automatic logic signed [20:0] atan_q(input int idx);
        logic [30:0] t;
        t = {1'b0, ATAN_Q30[idx]} + 31'd8192;
        return $signed({4'b0, t[30:14]});
    endfunction

    typedef struct packed {
        logic signed [33:0] x1;
        logic signed [33:0] y1;
        logic signed [20:0] z1;
        logic signed [33:0] x2;
        logic signed [33:0] y2;
        logic signed [20:0] z2;
        logic signed [29:0] dy;
        logic [23:0]        color;
    } t_cord;

    typedef struct packed {
        logic [48:0]        prod;
        logic               xpos;
        logic signed [21:0] ang;
        logic signed [29:0] dy;
        logic [23:0]        color;
    } t_mag;

    typedef struct packed {
        logic [33:0]        rem;
        logic [32:0]        mag;
        logic [18:0]        q;
        logic signed [21:0] ang;
        logic signed [29:0] dy;
        logic [23:0]        color;
    } t_div;

    typedef struct packed {
        logic signed [49:0] rp;
        logic signed [35:0] cp;
        logic [23:0]        color;
    } t_prd;
endpackage
`default_nettype wire

// ===== design/cylindrical_warp_pixel_mapper.sv =====
// Cylindrical forward warp of a pixel stream. Each input beat carries a source
// pixel (row, column, color); each output beat carries the destination row and
// column on a cylinder of focal length f, the color, and a write flag that is
// set only when the destination lies inside the target image (coordinates are
// zero otherwise). One beat is taken every clock unless the output stalls;
// the pipe is the input register, 24 CORDIC stages, one length multiply, one
// length select, 19 restoring divider stages, one product stage and the
// output register. A stall on the output freezes the whole pipe. The user
// must write registers through the plain write port while idle (not enforced).
`timescale 1ns / 1ps
`default_nettype none
module cylindrical_warp_pixel_mapper (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // src_row, src_col, pixel_color
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // dest_row, dest_col, out_color
    output logic             o_m_tuser,   // write_enable
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [12:0] i_cfg_data
);
    localparam int NS = cwpm_pkg::CORDIC_STEPS;
    localparam int NQ = cwpm_pkg::QUO_BITS;

    logic [12:0] r_focal, r_src_rows, r_src_cols, r_tgt_rows, r_tgt_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal    <= 13'd200;
            r_src_rows <= 13'd720;
            r_src_cols <= 13'd1280;
            r_tgt_rows <= 13'd720;
            r_tgt_cols <= 13'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                cwpm_pkg::REG_FOCAL:       r_focal    <= i_cfg_data;
                cwpm_pkg::REG_SOURCE_ROWS: r_src_rows <= i_cfg_data;
                cwpm_pkg::REG_SOURCE_COLS: r_src_cols <= i_cfg_data;
                cwpm_pkg::REG_TARGET_ROWS: r_tgt_rows <= i_cfg_data;
                cwpm_pkg::REG_TARGET_COLS: r_tgt_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic        w_adv;
    logic [12:0] w_f;
    assign w_f = (r_focal == 13'd0) ? 13'd1 : r_focal;

    cwpm_pkg::t_cord r_cd [NS+1];
    cwpm_pkg::t_cord n_cd [NS+1];
    logic [NS:0]     r_cv;
    cwpm_pkg::t_mag  r_mg, n_mg;
    logic            r_mv;
    cwpm_pkg::t_div  r_dv [NQ+1];
    cwpm_pkg::t_div  n_dv [NQ+1];
    logic [NQ:0]     r_dvv;
    cwpm_pkg::t_prd  r_pr, n_pr;
    logic            r_pv;
    logic [11:0]     r_row, r_col, n_row, n_col;
    logic [23:0]     r_color;
    logic            r_we, n_we, r_ov;

    assign w_adv      = !r_ov || i_m_tready;
    assign o_s_tready = w_adv;

    always_comb begin
        logic signed [33:0] fq, hc;
        fq = $signed({5'b0, w_f, 16'b0});
        hc = $signed({6'b0, r_src_cols, 15'b0});
        n_cd[0].x1    = fq;
        n_cd[0].y1    = $signed({6'b0, i_s_tdata[23:12], 16'b0}) - hc;
        n_cd[0].z1    = '0;
        n_cd[0].x2    = fq;
        n_cd[0].y2    = hc;
        n_cd[0].z2    = '0;
        n_cd[0].dy    = $signed({2'b0, i_s_tdata[11:0], 16'b0})
                      - $signed({2'b0, r_src_rows, 15'b0});
        n_cd[0].color = i_s_tdata[47:24];
        for (int i = 0; i < NS; i++) begin
            n_cd[i+1] = r_cd[i];
            if (!r_cd[i].y1[33]) begin
                n_cd[i+1].x1 = r_cd[i].x1 + (r_cd[i].y1 >>> i);
                n_cd[i+1].y1 = r_cd[i].y1 - (r_cd[i].x1 >>> i);
                n_cd[i+1].z1 = r_cd[i].z1 + cwpm_pkg::atan_q(i);
            end else begin
                n_cd[i+1].x1 = r_cd[i].x1 - (r_cd[i].y1 >>> i);
                n_cd[i+1].y1 = r_cd[i].y1 + (r_cd[i].x1 >>> i);
                n_cd[i+1].z1 = r_cd[i].z1 - cwpm_pkg::atan_q(i);
            end
            if (!r_cd[i].y2[33]) begin
                n_cd[i+1].x2 = r_cd[i].x2 + (r_cd[i].y2 >>> i);
                n_cd[i+1].y2 = r_cd[i].y2 - (r_cd[i].x2 >>> i);
                n_cd[i+1].z2 = r_cd[i].z2 + cwpm_pkg::atan_q(i);
            end else begin
                n_cd[i+1].x2 = r_cd[i].x2 - (r_cd[i].y2 >>> i);
                n_cd[i+1].y2 = r_cd[i].y2 + (r_cd[i].x2 >>> i);
                n_cd[i+1].z2 = r_cd[i].z2 - cwpm_pkg::atan_q(i);
            end
        end
    end

    always_comb begin
        n_mg.prod  = r_cd[NS].x1[32:0] * {33'b0, cwpm_pkg::KF};
        n_mg.xpos  = !r_cd[NS].x1[33] && (r_cd[NS].x1 != '0);
        n_mg.ang   = 22'(r_cd[NS].z1) + 22'(r_cd[NS].z2);
        n_mg.dy    = r_cd[NS].dy;
        n_mg.color = r_cd[NS].color;
    end

    // quotient of (f << 32) / mag is below 2^19, so only zeros shift in
    always_comb begin
        logic [32:0] mag;
        logic [33:0] sh;
        mag = r_mg.xpos ? r_mg.prod[48:16] : 33'd0;
        if (mag == 33'd0) begin
            mag = 33'd1;
        end
        n_dv[0].rem   = {8'b0, w_f, 13'b0};
        n_dv[0].mag   = mag;
        n_dv[0].q     = '0;
        n_dv[0].ang   = r_mg.ang;
        n_dv[0].dy    = r_mg.dy;
        n_dv[0].color = r_mg.color;
        for (int k = 0; k < NQ; k++) begin
            n_dv[k+1] = r_dv[k];
            sh = {r_dv[k].rem[32:0], 1'b0};
            if (sh >= {1'b0, r_dv[k].mag}) begin
                n_dv[k+1].rem = sh - {1'b0, r_dv[k].mag};
                n_dv[k+1].q   = {r_dv[k].q[17:0], 1'b1};
            end else begin
                n_dv[k+1].rem = sh;
                n_dv[k+1].q   = {r_dv[k].q[17:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_pr.rp    = 50'(r_dv[NQ].dy * $signed({1'b0, r_dv[NQ].q}));
        n_pr.cp    = 36'($signed({1'b0, w_f}) * r_dv[NQ].ang);
        n_pr.color = r_dv[NQ].color;
    end

    always_comb begin
        logic signed [51:0] uq;
        logic signed [19:0] rv, cv;
        uq = 52'(r_pr.rp) + $signed({8'b0, r_src_rows, 31'b0});
        rv = 20'(uq >>> 32);
        if (uq[51] && (uq[31:0] != '0)) begin
            rv = rv + 20'sd1;
        end
        cv = 20'(r_pr.cp >>> 16);
        if (r_pr.cp[35] && (r_pr.cp[15:0] != '0)) begin
            cv = cv + 20'sd1;
        end
        n_we = !rv[19] && (rv[19:12] == '0) && (rv[12:0] < r_tgt_rows)
            && !cv[19] && (cv[19:12] == '0) && (cv[12:0] < r_tgt_cols);
        n_row = n_we ? rv[11:0] : '0;
        n_col = n_we ? cv[11:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv  <= '0;
            r_mv  <= 1'b0;
            r_dvv <= '0;
            r_pv  <= 1'b0;
            r_ov  <= 1'b0;
        end else if (w_adv) begin
            r_cv  <= {r_cv[NS-1:0], i_s_tvalid};
            r_mv  <= r_cv[NS];
            r_dvv <= {r_dvv[NQ-1:0], r_mv};
            r_pv  <= r_dvv[NQ];
            r_ov  <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i <= NS; i++) begin
                r_cd[i] <= n_cd[i];
            end
            r_mg <= n_mg;
            for (int k = 0; k <= NQ; k++) begin
                r_dv[k] <= n_dv[k];
            end
            r_pr    <= n_pr;
            r_row   <= n_row;
            r_col   <= n_col;
            r_we    <= n_we;
            r_color <= r_pr.color;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_color, r_col, r_row};
    assign o_m_tuser  = r_we;

    a_zero_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_we |-> (r_row == '0) && (r_col == '0))
        else $error("coordinates not cleared for pixel outside target");

    a_inside_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_we |-> ({1'b0, r_row} < r_tgt_rows) && ({1'b0, r_col} < r_tgt_cols))
        else $error("write flag set outside target");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_cv[0])
        else $error("accepted beat lost at pipe entry");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dvv[NQ] |-> r_dv[NQ].rem < {1'b0, r_dv[NQ].mag})
        else $error("divider remainder out of range");
endmodule
`default_nettype wire

// ===== verif/tb_cylindrical_warp_pixel_mapper.sv =====
`timescale 1ns / 1ps
module tb_cylindrical_warp_pixel_mapper;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam logic [2:0] REG_RSVD   = 3'd5;
    localparam int PIPE_DRAIN = 60;

    typedef struct {
        logic [11:0] row;
        logic [11:0] col;
        logic [23:0] color;
        logic        we;
    } t_dest;

    typedef struct {
        logic [11:0] row;
        logic [11:0] col;
        logic [23:0] color;
        logic        typed;
        logic        we;
    } t_stim;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;   // src_row, src_col, pixel_color
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;   // dest_row, dest_col, out_color
    logic        o_m_tuser;   // write_enable
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [12:0] i_cfg_data;

    cylindrical_warp_pixel_mapper u_top (.*);

    logic [12:0] cfg_focal, cfg_srows, cfg_scols, cfg_trows, cfg_tcols;
    t_dest       dest_q[$];
    int          errs;
    bit          typed_now;
    t_dest       typed_dest;
    bit          sink_busy;
    bit          src_busy;
    int          stall_cnt;
    int          sink_r;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint trunc_shr(longint v, int s);
        return (v >= 0) ? (v >>> s) : -((-v) >>> s);
    endfunction

    function automatic void cordic_vector(longint x0, longint y0,
                                          output longint xo, output longint zo);
        longint x, y, z, xs, ys, a;
        x = x0;
        y = y0;
        z = 0;
        for (int i = 0; i < cwpm_pkg::CORDIC_STEPS; i++) begin
            a  = (longint'(cwpm_pkg::ATAN_Q30[i])
                 + (longint'(1) << (29 - cwpm_pkg::FRAC_BITS)))
                 >>> (30 - cwpm_pkg::FRAC_BITS);
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += a;
            end else begin
                x -= ys;
                y += xs;
                z -= a;
            end
        end
        xo = x;
        zo = z;
    endfunction

    function automatic t_dest warp_pixel(logic [11:0] r, logic [11:0] c, logic [23:0] color);
        longint f, hr, hc, dy, dx, xr, a1, xn, a2, mag, cs, uq, row, col;
        t_dest d;
        f  = (cfg_focal != 0) ? longint'(cfg_focal) : 1;
        hr = longint'(cfg_srows) <<< (cwpm_pkg::FRAC_BITS - 1);
        hc = longint'(cfg_scols) <<< (cwpm_pkg::FRAC_BITS - 1);
        dy = (longint'(r) <<< cwpm_pkg::FRAC_BITS) - hr;
        dx = (longint'(c) <<< cwpm_pkg::FRAC_BITS) - hc;
        cordic_vector(f <<< cwpm_pkg::FRAC_BITS, dx, xr, a1);
        cordic_vector(f <<< cwpm_pkg::FRAC_BITS, hc, xn, a2);
        mag = (xr > 0) ? ((xr * longint'(cwpm_pkg::KF)) >>> cwpm_pkg::FRAC_BITS) : 0;
        if (mag < 1) mag = 1;
        cs  = (f <<< (2 * cwpm_pkg::FRAC_BITS)) / mag;
        uq  = dy * cs + (hr <<< cwpm_pkg::FRAC_BITS);
        row = trunc_shr(uq, 2 * cwpm_pkg::FRAC_BITS);
        col = trunc_shr(f * (a1 + a2), cwpm_pkg::FRAC_BITS);
        d.we = row >= 0 && row < longint'(cfg_trows) && row < cwpm_pkg::MAX_DIM &&
               col >= 0 && col < longint'(cfg_tcols) && col < cwpm_pkg::MAX_DIM;
        d.row   = d.we ? row[11:0] : '0;
        d.col   = d.we ? col[11:0] : '0;
        d.color = color;
        return d;
    endfunction

    // input beat taken at the coming edge
    always @(negedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            if (typed_now)
                dest_q.push_back(typed_dest);
            else
                dest_q.push_back(warp_pixel(i_s_tdata[11:0], i_s_tdata[23:12],
                                            i_s_tdata[47:24]));
        end
    end

    always @(negedge i_clk) begin
        t_dest e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (dest_q.size() == 0) begin
                $display("%0t: unexpected beat row=%0d col=%0d color=%h we=%b", $time,
                         o_m_tdata[11:0], o_m_tdata[23:12], o_m_tdata[47:24], o_m_tuser);
                errs++;
            end else begin
                e = dest_q.pop_front();
                if (o_m_tdata[11:0] !== e.row || o_m_tdata[23:12] !== e.col ||
                    o_m_tdata[47:24] !== e.color || o_m_tuser !== e.we) begin
                    $display("%0t: expected row=%0d col=%0d color=%h we=%b,", $time,
                             e.row, e.col, e.color, e.we,
                             " got row=%0d col=%0d color=%h we=%b", o_m_tdata[11:0],
                             o_m_tdata[23:12], o_m_tdata[47:24], o_m_tuser);
                    errs++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_cnt  <= 0;
        end else if (stall_cnt > 0) begin
            stall_cnt  <= stall_cnt - 1;
            i_m_tready <= 1'b0;
        end else if (sink_busy) begin
            sink_r = $urandom_range(0, 99);
            if (sink_r < 3) begin
                stall_cnt  <= $urandom_range(10, 40);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= (sink_r >= 30);
            end
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        if (!src_busy) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_pixel(t_stim s);
        int  g;
        bit  hit;
        g = pick_gap();
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        typed_now        = s.typed;
        typed_dest.row   = '0;
        typed_dest.col   = '0;
        typed_dest.color = s.color;
        typed_dest.we    = s.we;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {s.color, s.col, s.row};
        do begin
            @(negedge i_clk);
            hit = o_s_tready;
            @(posedge i_clk);
        end while (!hit);
    endtask

    task automatic drain_pipe();
        i_s_tvalid <= 1'b0;
        while (dest_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // the caller drops the write enable after its last write
    task automatic write_reg(logic [2:0] addr, logic [12:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (addr)
            cwpm_pkg::REG_FOCAL:       cfg_focal = val;
            cwpm_pkg::REG_SOURCE_ROWS: cfg_srows = val;
            cwpm_pkg::REG_SOURCE_COLS: cfg_scols = val;
            cwpm_pkg::REG_TARGET_ROWS: cfg_trows = val;
            cwpm_pkg::REG_TARGET_COLS: cfg_tcols = val;
            default: ;
        endcase
    endtask

    task automatic set_geometry(logic [12:0] f, logic [12:0] sr, logic [12:0] sc,
                                logic [12:0] tr, logic [12:0] tc);
        write_reg(cwpm_pkg::REG_FOCAL, f);
        write_reg(cwpm_pkg::REG_SOURCE_ROWS, sr);
        write_reg(cwpm_pkg::REG_SOURCE_COLS, sc);
        write_reg(cwpm_pkg::REG_TARGET_ROWS, tr);
        write_reg(cwpm_pkg::REG_TARGET_COLS, tc);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_pixels(int n);
        t_stim s;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) begin
                src_busy  = ($urandom_range(0, 3) != 0);
                sink_busy = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 3) == 0 || cfg_srows == 0 || cfg_scols == 0) begin
                s.row = 12'($urandom);
                s.col = 12'($urandom);
            end else begin
                s.row = 12'($urandom_range(0, (cfg_srows > 4096) ? 4095 : cfg_srows - 1));
                s.col = 12'($urandom_range(0, (cfg_scols > 4096) ? 4095 : cfg_scols - 1));
            end
            s.color = 24'($urandom);
            s.typed = 1'b0;
            s.we    = 1'b0;
            send_pixel(s);
        end
    endtask

    t_stim corner_tbl[] = '{
        '{12'd4095, 12'd640,  24'hFFFFFF, 1'b1, 1'b0},
        '{12'd4095, 12'd0,    24'h000000, 1'b1, 1'b0},
        '{12'd4095, 12'd1280, 24'hAAAAAA, 1'b1, 1'b0},
        '{12'd4000, 12'd640,  24'h555555, 1'b1, 1'b0},
        '{12'd0,    12'd0,    24'h000000, 1'b0, 1'b0},
        '{12'd0,    12'd4095, 24'hFFFFFF, 1'b0, 1'b0},
        '{12'd4095, 12'd4095, 24'h123456, 1'b0, 1'b0},
        '{12'd360,  12'd640,  24'hABCDEF, 1'b0, 1'b0},
        '{12'd359,  12'd639,  24'h800001, 1'b0, 1'b0},
        '{12'd719,  12'd1279, 24'h7FFFFE, 1'b0, 1'b0},
        '{12'd0,    12'd640,  24'h0F0F0F, 1'b0, 1'b0},
        '{12'd719,  12'd640,  24'hF0F0F0, 1'b0, 1'b0},
        '{12'd360,  12'd0,    24'h000001, 1'b0, 1'b0},
        '{12'd360,  12'd1279, 24'h800000, 1'b0, 1'b0},
        '{12'd100,  12'd200,  24'hC3C3C3, 1'b0, 1'b0},
        '{12'd600,  12'd1100, 24'h3C3C3C, 1'b0, 1'b0},
        '{12'd2048, 12'd2048, 24'h5A5A5A, 1'b0, 1'b0},
        '{12'd1,    12'd1,    24'hA5A5A5, 1'b0, 1'b0}
    };

    initial begin
        errs       = 0;
        typed_now  = 0;
        src_busy   = 0;
        sink_busy  = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        cfg_focal  = 13'd200;
        cfg_srows  = 13'd720;
        cfg_scols  = 13'd1280;
        cfg_trows  = 13'd720;
        cfg_tcols  = 13'd1024;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry, back to back then with gaps
        foreach (corner_tbl[k]) send_pixel(corner_tbl[k]);
        src_busy = 1;
        sink_busy = 1;
        foreach (corner_tbl[k]) send_pixel(corner_tbl[k]);
        typed_now = 0;
        random_pixels(60);
        drain_pipe();

        set_geometry(13'd1, 13'd1, 13'd1, 13'd1, 13'd1);
        random_pixels(90);
        drain_pipe();
        set_geometry(13'd5000, 13'd4096, 13'd4096, 13'd4096, 13'd4096);
        random_pixels(110);
        drain_pipe();
        // zero focal length behaves as one
        set_geometry(13'd0, 13'd720, 13'd1280, 13'd720, 13'd1024);
        random_pixels(90);
        drain_pipe();
        set_geometry(13'd8191, 13'd0, 13'd8191, 13'd8191, 13'd8191);
        random_pixels(90);
        drain_pipe();
        write_reg(REG_UNUSED, 13'd17);
        write_reg(REG_RSVD, 13'h1FFF);
        set_geometry(13'd300, 13'd480, 13'd640, 13'd480, 13'd640);
        random_pixels(90);
        drain_pipe();
        for (int p = 0; p < 2; p++) begin
            set_geometry(13'($urandom_range(1, 5000)), 13'($urandom_range(1, 4096)),
                         13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                         13'($urandom_range(1, 4096)));
            random_pixels(90);
            drain_pipe();
        end

        if (errs == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/cwpm_pkg.sv
design/cylindrical_warp_pixel_mapper.sv
verif/tb_cylindrical_warp_pixel_mapper.sv
